@@ rtl/i2csrb_pkg.sv @@
// ----------------------------------------------------------------------------
// i2csrb_pkg
// Shared types, codes and helpers for the I2C slave register bridge.
// ----------------------------------------------------------------------------
package i2csrb_pkg;

  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NBYTES  = 4;
  localparam int unsigned IDX_W   = 3;   // holds 0..NBYTES
  localparam int unsigned SEL_W   = 2;   // addresses one buffer entry
  localparam int unsigned MASK_W  = 4;

  // event kinds from the bit-shift unit
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_SHIFT = 1'b1;

  // shift-unit mode codes
  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_ACK  = 2'd2;

  // per-output command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;

  localparam logic [BYTE_W-1:0] TX_ACK = 8'h00;

  typedef struct packed {
    logic [1:0]        shift_mode;
    logic              sda_drive;
    logic              tx_load;
    logic [BYTE_W-1:0] tx_byte;
    logic              cmd_valid;
    logic [MASK_W-1:0] flag_toggle_mask;
    logic [1:0]        output_cmd_first;
    logic [1:0]        output_cmd_second;
    logic [1:0]        output_cmd_third;
    logic              led_pulse;
  } result_t;

  function automatic logic [1:0] out_cmd(input logic [BYTE_W-1:0] b);
    logic [1:0] c;
    c = CMD_NONE;
    if (b == 8'd2) c = CMD_SET;
    else if (b == 8'd1) c = CMD_CLEAR;
    return c;
  endfunction

endpackage

@@ rtl/i2c_slave_register_bridge_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_slave_register_bridge_unit
// Byte-level I2C slave sequencer bridging a 4-byte status read and a
// 4-byte command write.
// ----------------------------------------------------------------------------
// Usage:
//   Event channel (item_valid/item_stall): one item per bit-shift unit event,
//   either a start condition or the end of a byte or ack-bit shift, carrying
//   the shifted-in byte and the status bytes to snapshot on a read match.
//   Result channel (result_valid/result_stall): exactly one item per event,
//   giving shift mode, SDA drive, byte to load, command outputs and LED pulse.
//   Configuration: cfg_write/cfg_data load the 7-bit own address; write it
//   only while no event is in flight.
//   The result of an accepted event is valid in the next cycle. Throughput
//   is one item per cycle while the receiver does not stall, set by the
//   single result register behind the sequencer logic.
//   While the receiver stalls a waiting result, item_stall is raised and the
//   result holds; a new event is taken in the same cycle the result leaves.
//   Reset clears the phase to waiting for start, the byte counter, the own
//   address and the result valid flag; the data buffer is not cleared.
// ----------------------------------------------------------------------------
module i2c_slave_register_bridge_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [i2csrb_pkg::ADDR_W-1:0] cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          action,
  input  logic [i2csrb_pkg::BYTE_W-1:0] rx_byte,
  input  logic [i2csrb_pkg::BYTE_W-1:0] reset_flags,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_first,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_second,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_third,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [1:0]                    shift_mode,
  output logic                          sda_drive,
  output logic                          tx_load,
  output logic [i2csrb_pkg::BYTE_W-1:0] tx_byte,
  output logic                          cmd_valid,
  output logic [i2csrb_pkg::MASK_W-1:0] flag_toggle_mask,
  output logic [1:0]                    output_cmd_first,
  output logic [1:0]                    output_cmd_second,
  output logic [1:0]                    output_cmd_third,
  output logic                          led_pulse
);
  import i2csrb_pkg::*;

  logic [ADDR_W-1:0] own_address;
  logic              accept;
  result_t           res_next;
  result_t           res;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_write) begin
      own_address <= cfg_data;
    end
  end

  i2csrb_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .action        (action),
    .rx_byte       (rx_byte),
    .reset_flags   (reset_flags),
    .status_first  (status_first),
    .status_second (status_second),
    .status_third  (status_third),
    .own_address   (own_address),
    .res           (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!item_stall) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign shift_mode        = res.shift_mode;
  assign sda_drive         = res.sda_drive;
  assign tx_load           = res.tx_load;
  assign tx_byte           = res.tx_byte;
  assign cmd_valid         = res.cmd_valid;
  assign flag_toggle_mask  = res.flag_toggle_mask;
  assign output_cmd_first  = res.output_cmd_first;
  assign output_cmd_second = res.output_cmd_second;
  assign output_cmd_third  = res.output_cmd_third;
  assign led_pulse         = res.led_pulse;

  // a stalled result stays and the event side is held off
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(res))
    else $error("stalled result changed");

  // a completed command always goes out with an ack driven on SDA
  a_cmd_ack: assert property (@(posedge clk) disable iff (rst)
    result_valid && cmd_valid |-> sda_drive && tx_load && tx_byte == TX_ACK
      && shift_mode == MODE_ACK)
    else $error("command without ack");

  // SDA is driven only with a loaded byte
  a_drive_load: assert property (@(posedge clk) disable iff (rst)
    result_valid && sda_drive |-> tx_load)
    else $error("SDA driven without load");

  // an accepted item yields a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("result missing after accept");

endmodule

@@ rtl/i2csrb_seq.sv @@
// ----------------------------------------------------------------------------
// i2csrb_seq
// Byte-level protocol sequencer: phase, byte counter and data buffer,
// next-state and result logic for one event.
// ----------------------------------------------------------------------------
module i2csrb_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        action,
  input  logic [i2csrb_pkg::BYTE_W-1:0] rx_byte,
  input  logic [i2csrb_pkg::BYTE_W-1:0] reset_flags,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_first,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_second,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_third,
  input  logic [i2csrb_pkg::ADDR_W-1:0] own_address,
  output i2csrb_pkg::result_t         res
);
  import i2csrb_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_ADDR      = 3'd1;
  localparam logic [2:0] PH_SEND      = 3'd2;
  localparam logic [2:0] PH_SEND_WAIT = 3'd3;
  localparam logic [2:0] PH_SEND_ACK  = 3'd4;
  localparam logic [2:0] PH_RECV      = 3'd5;
  localparam logic [2:0] PH_RECV_ACK  = 3'd6;

  logic [2:0]        phase, phase_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [BYTE_W-1:0] byte_buffer [NBYTES];

  logic              load_all;
  logic              write_one;
  logic [SEL_W-1:0]  sel;
  logic              idx_room;

  assign sel      = byte_index[SEL_W-1:0];
  assign idx_room = (byte_index < IDX_W'(NBYTES));

  always_comb begin
    res             = '0;
    phase_next      = phase;
    byte_index_next = byte_index;
    load_all        = 1'b0;
    write_one       = 1'b0;
    if (action == ACT_START) begin
      phase_next     = PH_ADDR;
      res.shift_mode = MODE_BYTE;
    end else begin
      unique case (phase) inside
        PH_ADDR: begin
          if (rx_byte[BYTE_W-1:1] == own_address) begin
            res.led_pulse   = 1'b1;
            byte_index_next = '0;
            res.shift_mode  = MODE_ACK;
            res.sda_drive   = 1'b1;
            res.tx_load     = 1'b1;
            res.tx_byte     = TX_ACK;
            if (rx_byte[0]) begin
              load_all   = 1'b1;
              phase_next = PH_SEND;
            end else begin
              phase_next = PH_RECV_ACK;
            end
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_SEND, PH_SEND_WAIT: begin
          // a nonzero ack bit from the master ends the read
          if ((phase == PH_SEND_WAIT && rx_byte != '0) || !idx_room) begin
            phase_next = PH_IDLE;
          end else begin
            res.shift_mode  = MODE_BYTE;
            res.sda_drive   = 1'b1;
            res.tx_load     = 1'b1;
            res.tx_byte     = byte_buffer[sel];
            res.led_pulse   = 1'b1;
            byte_index_next = byte_index + 1'b1;
            phase_next      = PH_SEND_ACK;
          end
        end
        PH_SEND_ACK: begin
          phase_next     = PH_SEND_WAIT;
          res.shift_mode = MODE_ACK;
          res.tx_load    = 1'b1;
          res.tx_byte    = TX_ACK;
        end
        PH_RECV: begin
          if (idx_room) begin
            write_one       = 1'b1;
            byte_index_next = byte_index + 1'b1;
            if (byte_index == IDX_W'(NBYTES - 1)) begin
              // last byte is still on rx_byte, not yet in the buffer
              res.cmd_valid         = 1'b1;
              res.flag_toggle_mask  = byte_buffer[0][MASK_W-1:0];
              res.output_cmd_first  = out_cmd(byte_buffer[1]);
              res.output_cmd_second = out_cmd(byte_buffer[2]);
              res.output_cmd_third  = out_cmd(rx_byte);
            end
          end
          phase_next     = PH_RECV_ACK;
          res.shift_mode = MODE_ACK;
          res.sda_drive  = 1'b1;
          res.tx_load    = 1'b1;
          res.tx_byte    = TX_ACK;
          res.led_pulse  = 1'b1;
        end
        PH_RECV_ACK: begin
          phase_next     = PH_RECV;
          res.shift_mode = MODE_BYTE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_index <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && load_all) begin
      byte_buffer[0] <= reset_flags;
      byte_buffer[1] <= status_first;
      byte_buffer[2] <= status_second;
      byte_buffer[3] <= status_third;
    end else if (accept && write_one) begin
      byte_buffer[sel] <= rx_byte;
    end
  end

endmodule

@@ verif/i2csrb_bus_checker.sv @@
// ----------------------------------------------------------------------------
// i2csrb_bus_checker
// Watches the event and result channels of the I2C slave register bridge.
// It tracks the slave sequencer (phase, byte counter, frame buffer and own
// address), predicts one response per accepted event and compares each
// accepted result field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module i2csrb_bus_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [i2csrb_pkg::ADDR_W-1:0] cfg_data,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  logic                          action,
  input  logic [i2csrb_pkg::BYTE_W-1:0] rx_byte,
  input  logic [i2csrb_pkg::BYTE_W-1:0] reset_flags,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_first,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_second,
  input  logic [i2csrb_pkg::BYTE_W-1:0] status_third,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  logic [1:0]                    shift_mode,
  input  logic                          sda_drive,
  input  logic                          tx_load,
  input  logic [i2csrb_pkg::BYTE_W-1:0] tx_byte,
  input  logic                          cmd_valid,
  input  logic [i2csrb_pkg::MASK_W-1:0] flag_toggle_mask,
  input  logic [1:0]                    output_cmd_first,
  input  logic [1:0]                    output_cmd_second,
  input  logic [1:0]                    output_cmd_third,
  input  logic                          led_pulse,
  output int                            fail_count,
  output int                            responses_due
);
  import i2csrb_pkg::*;

  typedef enum logic [2:0] {
    BUS_IDLE, BUS_ADDR, BUS_TX, BUS_TX_WAIT, BUS_TX_ACK, BUS_RX, BUS_RX_ACK
  } bus_phase_t;

  bus_phase_t        bus_phase;
  logic [IDX_W-1:0]  byte_count;
  logic [BYTE_W-1:0] frame_bytes [NBYTES];
  logic [ADDR_W-1:0] slave_addr;
  result_t           pending_responses [$];
  result_t           seen;
  result_t           want;

  function automatic logic [1:0] output_command(input logic [BYTE_W-1:0] b);
    case (b)
      8'd1:    return CMD_CLEAR;
      8'd2:    return CMD_SET;
      default: return CMD_NONE;
    endcase
  endfunction

  // snap holds {status_third, status_second, status_first, reset_flags}
  function automatic result_t bus_response(input logic act, input logic [BYTE_W-1:0] rx,
                                           input logic [4*BYTE_W-1:0] snap);
    result_t r;
    r = '0;
    if (act == ACT_START) begin
      bus_phase = BUS_ADDR;
      r.shift_mode = MODE_BYTE;
    end else begin
      case (bus_phase) inside
        BUS_ADDR: begin
          if (rx[7:1] == slave_addr) begin
            if (rx[0]) begin
              for (int i = 0; i < NBYTES; i++) frame_bytes[i] = snap[BYTE_W*i +: BYTE_W];
              bus_phase = BUS_TX;
            end else begin
              bus_phase = BUS_RX_ACK;
            end
            byte_count = '0;
            r.shift_mode = MODE_ACK;
            r.sda_drive = 1'b1;
            r.tx_load = 1'b1;
            r.tx_byte = TX_ACK;
            r.led_pulse = 1'b1;
          end else begin
            bus_phase = BUS_IDLE;
          end
        end
        BUS_TX, BUS_TX_WAIT: begin
          // nak from the master or all four bytes gone: release the bus
          if ((bus_phase == BUS_TX_WAIT && rx != 8'd0) || byte_count >= NBYTES) begin
            bus_phase = BUS_IDLE;
          end else begin
            r.shift_mode = MODE_BYTE;
            r.sda_drive = 1'b1;
            r.tx_load = 1'b1;
            r.tx_byte = frame_bytes[byte_count[SEL_W-1:0]];
            r.led_pulse = 1'b1;
            byte_count = byte_count + 1'b1;
            bus_phase = BUS_TX_ACK;
          end
        end
        BUS_TX_ACK: begin
          bus_phase = BUS_TX_WAIT;
          r.shift_mode = MODE_ACK;
          r.tx_load = 1'b1;
          r.tx_byte = TX_ACK;
        end
        BUS_RX: begin
          // bytes past the fourth are acked and dropped
          if (byte_count < NBYTES) begin
            frame_bytes[byte_count[SEL_W-1:0]] = rx;
            byte_count = byte_count + 1'b1;
            if (byte_count == NBYTES) begin
              r.cmd_valid = 1'b1;
              r.flag_toggle_mask = frame_bytes[0][MASK_W-1:0];
              r.output_cmd_first = output_command(frame_bytes[1]);
              r.output_cmd_second = output_command(frame_bytes[2]);
              r.output_cmd_third = output_command(frame_bytes[3]);
            end
          end
          bus_phase = BUS_RX_ACK;
          r.shift_mode = MODE_ACK;
          r.sda_drive = 1'b1;
          r.tx_load = 1'b1;
          r.tx_byte = TX_ACK;
          r.led_pulse = 1'b1;
        end
        BUS_RX_ACK: begin
          bus_phase = BUS_RX;
          r.shift_mode = MODE_BYTE;
        end
        default: bus_phase = BUS_IDLE;
      endcase
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bus_phase = BUS_IDLE;
      byte_count = '0;
      slave_addr = '0;
      pending_responses.delete();
      responses_due = 0;
      fail_count = 0;
    end else begin
      if (cfg_write) slave_addr = cfg_data;
      // retire the result first: an item taken at this edge answers later
      if (result_valid && !result_stall) begin
        seen = {shift_mode, sda_drive, tx_load, tx_byte, cmd_valid, flag_toggle_mask,
                output_cmd_first, output_cmd_second, output_cmd_third, led_pulse};
        if (pending_responses.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          want = pending_responses.pop_front();
          compare_field("shift_mode", want.shift_mode, seen.shift_mode);
          compare_field("sda_drive", want.sda_drive, seen.sda_drive);
          compare_field("tx_load", want.tx_load, seen.tx_load);
          compare_field("tx_byte", want.tx_byte, seen.tx_byte);
          compare_field("cmd_valid", want.cmd_valid, seen.cmd_valid);
          compare_field("flag_toggle_mask", want.flag_toggle_mask, seen.flag_toggle_mask);
          compare_field("output_cmd_first", want.output_cmd_first, seen.output_cmd_first);
          compare_field("output_cmd_second", want.output_cmd_second, seen.output_cmd_second);
          compare_field("output_cmd_third", want.output_cmd_third, seen.output_cmd_third);
          compare_field("led_pulse", want.led_pulse, seen.led_pulse);
        end
      end
      if (item_valid && !item_stall)
        pending_responses.push_back(bus_response(action, rx_byte,
          {status_third, status_second, status_first, reset_flags}));
      responses_due = pending_responses.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the I2C slave register bridge. Drives directed
// bus frames, then random read, write, mismatch and noise sequences under
// three idling mixes and a long receiver hold-off; the checker beside the
// block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import i2csrb_pkg::*;

  localparam int ITEMS_PER_PHASE = 600;
  localparam int HOLD_CYCLES     = 60;
  localparam int CYCLE_LIMIT     = 200000;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [ADDR_W-1:0] cfg_data;
  logic              item_valid;
  logic              item_stall;
  logic              action;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] reset_flags;
  logic [BYTE_W-1:0] status_first;
  logic [BYTE_W-1:0] status_second;
  logic [BYTE_W-1:0] status_third;
  logic              result_valid;
  logic              result_stall;
  logic [1:0]        shift_mode;
  logic              sda_drive;
  logic              tx_load;
  logic [BYTE_W-1:0] tx_byte;
  logic              cmd_valid;
  logic [MASK_W-1:0] flag_toggle_mask;
  logic [1:0]        output_cmd_first;
  logic [1:0]        output_cmd_second;
  logic [1:0]        output_cmd_third;
  logic              led_pulse;
  int                fail_count;
  int                responses_due;

  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int                items_sent;
  int                cycle_count;
  logic [ADDR_W-1:0] bridge_addr;

  i2c_slave_register_bridge_unit DUT (.*);
  i2csrb_bus_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // receiver: random stalls, or one long hold-off when requested
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_cmd_byte();
    case ($urandom_range(3))
      0:       return 8'd1;
      1:       return 8'd2;
      2:       return 8'd0;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic offer_event(input logic act, input logic [BYTE_W-1:0] rx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    rx_byte <= rx;
    reset_flags <= pick_byte();
    status_first <= pick_byte();
    status_second <= pick_byte();
    status_third <= pick_byte();
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  // n_acked data bytes get an ack; the next one gets a nak or is cut short
  task automatic read_frame(input int n_acked, input bit end_nak);
    offer_event(ACT_START, pick_byte());
    offer_event(ACT_SHIFT, {bridge_addr, 1'b1});
    offer_event(ACT_SHIFT, pick_byte());
    for (int i = 0; i < NBYTES; i++) begin
      offer_event(ACT_SHIFT, pick_byte());
      if (i < n_acked) begin
        offer_event(ACT_SHIFT, TX_ACK);
      end else begin
        if (end_nak) offer_event(ACT_SHIFT, 8'($urandom_range(1, 255)));
        break;
      end
    end
  endtask

  // data holds bytes 0..3 low first; bytes past the fourth are random
  task automatic write_frame(input logic [4*BYTE_W-1:0] data, input int n_bytes);
    offer_event(ACT_START, pick_byte());
    offer_event(ACT_SHIFT, {bridge_addr, 1'b0});
    for (int i = 0; i < n_bytes; i++) begin
      offer_event(ACT_SHIFT, pick_byte());
      offer_event(ACT_SHIFT, (i < NBYTES) ? data[BYTE_W*i +: BYTE_W] : pick_byte());
    end
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (responses_due != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_address(input logic [ADDR_W-1:0] a);
    settle();
    cfg_write <= 1'b1;
    cfg_data <= a;
    bridge_addr = a;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int target;
    int pick;
    logic [ADDR_W-1:0] other;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    item_valid = 1'b0;
    action = ACT_START;
    rx_byte = '0;
    reset_flags = '0;
    status_first = '0;
    status_second = '0;
    status_third = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b0;
    items_sent = 0;
    bridge_addr = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed frames at the reset address
    offer_event(ACT_SHIFT, 8'hFF);          // overflow while idle
    offer_event(ACT_START, 8'h00);
    offer_event(ACT_SHIFT, 8'hFE);          // address mismatch
    write_frame({8'h07, 8'h01, 8'h02, 8'hFF}, 5);
    read_frame(4, 1'b0);
    read_frame(1, 1'b1);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (p)
        0:       set_address(7'h7F);
        1:       set_address(7'($urandom_range(1, 126)));
        default: set_address(7'h00);
      endcase
      if (p == 2) hold_req = 1'b1;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          read_frame($urandom_range(NBYTES), 1'($urandom));
        end else if (pick < 75) begin
          write_frame({pick_cmd_byte(), pick_cmd_byte(), pick_cmd_byte(), 8'($urandom)},
                      $urandom_range(1, 6));
        end else if (pick < 85) begin
          other = 7'($urandom);
          if (other == bridge_addr) other = ~other;
          offer_event(ACT_START, pick_byte());
          offer_event(ACT_SHIFT, {other, 1'($urandom)});
        end else begin
          repeat ($urandom_range(1, 3)) offer_event(1'($urandom), 8'($urandom));
        end
      end
    end

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/i2csrb_pkg.sv
rtl/i2csrb_seq.sv
rtl/i2c_slave_register_bridge_unit.sv
verif/i2csrb_bus_checker.sv
verif/testbench.sv
